@@ hw/rtl/falc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package falc_pkg;

  localparam int ENTRIES = 64;
  localparam int KEY_W   = 32;
  localparam int CNT_W   = 32;
  localparam int CAP_W   = 7;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W   = $clog2(ENTRIES + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_UPDATE
  } state_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic             compare;
    logic             commit;
    logic [IDX_W-1:0] lim;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/falc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface falc_acc_if import falc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink (input valid, input key, output ready);
endinterface

interface falc_res_if import falc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic             evicted;
  logic [KEY_W-1:0] evicted_key;
  logic [CNT_W-1:0] hit_count;
  logic [CNT_W-1:0] access_count;

  modport source (output valid, output hit, output evicted, output evicted_key,
                  output hit_count, output access_count, input ready);
  modport sink (input valid, input hit, input evicted, input evicted_key,
                input hit_count, input access_count, output ready);
endinterface

interface falc_cfg_if import falc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fully_assoc_lru_cache_sim_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Fully associative LRU key store built as a chain of cells kept in recency
// order: the head cell holds the most recent key and the last valid cell the
// least recent one. An access goes in order: the key beat is taken, every cell
// compares against it in parallel, then, once the output register is free, the
// chain shifts by one place up to the hit position (on a miss, the tail if full,
// else the first free cell) while the new key enters the head. A result is held
// in an output register, so the next key is taken while the previous result
// still waits. Capacity writes are taken at any time; zero acts as one, values
// above the cell count act as that count. Both counters stick at all ones.
module fully_assoc_lru_cache_sim_core import falc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  falc_acc_if.sink   acc,
  falc_res_if.source res,
  falc_cfg_if.sink   cfg
);

  state_t state, state_next;

  logic [KEY_W-1:0] key_q;
  logic [CAP_W-1:0] capacity_q;
  logic [OCC_W-1:0] occ_q;
  logic [CNT_W-1:0] hits_q;
  logic [CNT_W-1:0] accesses_q;

  logic             res_valid_q;
  logic             res_hit_q;
  logic             res_evicted_q;
  logic [KEY_W-1:0] res_evicted_key_q;

  cell_ctrl_t       ctrl;
  logic             commit;

  logic [KEY_W-1:0] cell_key   [ENTRIES];
  logic             cell_valid [ENTRIES];
  logic [ENTRIES-1:0] cell_match;
  logic [KEY_W-1:0] cell_tail  [ENTRIES];

  logic             hit;
  logic [IDX_W-1:0] hit_pos;
  logic [KEY_W-1:0] tail_key;
  logic [OCC_W-1:0] cap_eff;
  logic             full;
  logic [CNT_W-1:0] hits_next;
  logic [CNT_W-1:0] accesses_next;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      falc_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .idx        (IDX_W'(g)),
        .lookup_key (key_q),
        .prev_key   ((g == 0) ? key_q : cell_key[(g == 0) ? 0 : g - 1]),
        .prev_valid ((g == 0) ? 1'b1 : cell_valid[(g == 0) ? 0 : g - 1]),
        .next_valid ((g == ENTRIES - 1) ? 1'b0
                     : cell_valid[(g == ENTRIES - 1) ? g : g + 1]),
        .key        (cell_key[g]),
        .valid      (cell_valid[g]),
        .match      (cell_match[g]),
        .tail_key   (cell_tail[g])
      );
    end
  endgenerate

  // matches are one-hot and only the tail cell passes its key, so plain ors do
  always_comb begin
    hit_pos  = '0;
    tail_key = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_pos  = hit_pos | (cell_match[i] ? IDX_W'(i) : '0);
      tail_key = tail_key | cell_tail[i];
    end
  end

  assign hit = |cell_match;

  always_comb begin
    if (capacity_q == '0) begin
      cap_eff = OCC_W'(1);
    end else if (32'(capacity_q) > 32'(ENTRIES)) begin
      cap_eff = OCC_W'(ENTRIES);
    end else begin
      cap_eff = OCC_W'(capacity_q);
    end
  end

  assign full          = occ_q >= cap_eff;
  assign hits_next     = (hit && hits_q != CNT_MAX) ? hits_q + 1'b1 : hits_q;
  assign accesses_next = (accesses_q != CNT_MAX) ? accesses_q + 1'b1 : accesses_q;

  always_comb begin
    state_next   = state;
    commit       = 1'b0;
    ctrl.compare = 1'b0;
    ctrl.commit  = 1'b0;
    if (hit) begin
      ctrl.lim = hit_pos;
    end else if (full) begin
      ctrl.lim = IDX_W'(occ_q - 1'b1);
    end else begin
      ctrl.lim = IDX_W'(occ_q);
    end
    case (state)
      ST_IDLE: begin
        if (acc.valid) begin
          state_next = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        ctrl.compare = 1'b1;
        state_next   = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!res_valid_q || res.ready) begin
          commit      = 1'b1;
          ctrl.commit = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_q  <= CAP_RESET;
      occ_q       <= '0;
      hits_q      <= '0;
      accesses_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg.valid) begin
        capacity_q <= cfg.capacity;
      end
      if (commit) begin
        hits_q      <= hits_next;
        accesses_q  <= accesses_next;
        res_valid_q <= 1'b1;
        if (!hit && !full) begin
          occ_q <= occ_q + 1'b1;
        end
      end else if (res.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc.valid && acc.ready) begin
      key_q <= acc.key;
    end
    if (commit) begin
      res_hit_q         <= hit;
      res_evicted_q     <= !hit && full;
      res_evicted_key_q <= (!hit && full) ? tail_key : '0;
    end
  end

  assign acc.ready        = (state == ST_IDLE);
  assign cfg.ready        = 1'b1;
  assign res.valid        = res_valid_q;
  assign res.hit          = res_hit_q;
  assign res.evicted      = res_evicted_q;
  assign res.evicted_key  = res_evicted_key_q;
  assign res.hit_count    = hits_q;
  assign res.access_count = accesses_q;

endmodule

`default_nettype wire

@@ hw/rtl/falc_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module falc_cell import falc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctrl_t       ctrl,
  input  logic [IDX_W-1:0] idx,
  input  logic [KEY_W-1:0] lookup_key,
  input  logic [KEY_W-1:0] prev_key,
  input  logic             prev_valid,
  input  logic             next_valid,
  output logic [KEY_W-1:0] key,
  output logic             valid,
  output logic             match,
  output logic [KEY_W-1:0] tail_key
);

  logic [KEY_W-1:0] key_q;
  logic             valid_q;
  logic             match_q;
  logic [KEY_W-1:0] tail_key_q;
  logic             shift_in;
  logic             is_tail;

  // cells up to the limit take their neighbour's entry, the head takes the new key
  assign shift_in = ctrl.commit && (idx <= ctrl.lim);
  assign is_tail  = valid_q && !next_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (shift_in) begin
        valid_q <= prev_valid;
      end
      if (ctrl.compare) begin
        match_q <= valid_q && (key_q == lookup_key);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_in) begin
      key_q <= prev_key;
    end
    if (ctrl.compare) begin
      tail_key_q <= is_tail ? key_q : '0;
    end
  end

  assign key      = key_q;
  assign valid    = valid_q;
  assign match    = match_q;
  assign tail_key = tail_key_q;

endmodule

`default_nettype wire
